// ----- src/msbl_pkg.sv -----
// Shared types and constants for the masked 1bpp sprite blitter.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package msbl_pkg;

  localparam int WORD_W = 16;
  localparam int OFF_W  = 4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_DRAW  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ----- src/masked_sprite_blitter_1bpp.sv -----
// Sprite write goes straight into the sprite RAM. Read: registered frame RAM read, then the
// output register. Draw: one sprite word and its frame word read per cycle, merged word
// written from the s1 stage if inside the frame. Clear: one frame word written per cycle.
// One command at a time; in_stall is high until the command completes.
// Reset (rst_n, synchronous, active low) clears control state only; stores are undefined.
// Depends on msbl_pkg and msbl_ram.
`default_nettype none

module masked_sprite_blitter_1bpp import msbl_pkg::*; #(
  parameter int SPRITE_SLOTS   = 64,
  parameter int SPRITE_ROWS    = 16,
  parameter int SPRITE_WORDS_X = 4,
  parameter int FB_WORDS_X     = 32,
  parameter int FB_ROWS        = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_sprite_index,
  input  wire logic [5:0]  in_word_index,
  input  wire logic [15:0] in_color_word,
  input  wire logic [15:0] in_alpha_word,
  input  wire logic [8:0]  in_pos_x,
  input  wire logic [8:0]  in_pos_y,
  input  wire logic        in_background_white,
  input  wire logic [13:0] in_fb_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data
);

  localparam int WPS       = SPRITE_ROWS * SPRITE_WORDS_X;
  localparam int SPR_DEPTH = SPRITE_SLOTS * WPS;
  localparam int FB_DEPTH  = FB_ROWS * FB_WORDS_X;
  localparam int SA_W      = (SPR_DEPTH > 1) ? $clog2(SPR_DEPTH) : 1;
  localparam int FA_W      = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int R_W       = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
  localparam int C_W       = (SPRITE_WORDS_X > 1) ? $clog2(SPRITE_WORDS_X) : 1;

  state_t            state_r, state_nxt;
  logic [5:0]        slot_r, slot_nxt;
  logic [4:0]        col0_r, col0_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [8:0]        py_r, py_nxt;
  logic [R_W-1:0]    row_r, row_nxt;
  logic [C_W-1:0]    col_r, col_nxt;
  logic              white_r, white_nxt;
  logic [FA_W-1:0]   clr_r, clr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_wen_r, s1_wen_nxt;
  logic              s1_first_r, s1_first_nxt;
  logic [FA_W-1:0]   s1_fa_r, s1_fa_nxt;
  logic [WORD_W-1:0] prev_col_r, prev_col_nxt;
  logic [WORD_W-1:0] prev_msk_r, prev_msk_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  logic              accept;
  logic              slot_ok;
  logic [10:0]       fy;
  logic [6:0]        fx;
  logic              iss_wen;
  logic [FA_W-1:0]   iss_fa;
  logic [FA_W-1:0]   rd_fa;

  logic              spr_we;
  logic [SA_W-1:0]   spr_waddr, spr_raddr;
  logic [31:0]       spr_rdata;
  logic              fb_we;
  logic [FA_W-1:0]   fb_waddr, fb_raddr;
  logic [WORD_W-1:0] fb_wdata, fb_rdata;

  logic [WORD_W-1:0] pc, pm, sh_col, sh_msk, merged;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign slot_ok   = 32'(in_sprite_index) < SPRITE_SLOTS;

  assign spr_we    = accept && (in_cmd == CMD_WRITE) && slot_ok && (32'(in_word_index) < WPS);
  assign spr_waddr = SA_W'(32'(in_sprite_index) * WPS + 32'(in_word_index));
  assign spr_raddr = SA_W'(32'(slot_r) * WPS + 32'(row_r) * SPRITE_WORDS_X + 32'(col_r));

  assign fy      = 11'(py_r) + 11'(row_r);
  assign fx      = 7'(col0_r) + 7'(col_r);
  assign iss_wen = (32'(fy) < FB_ROWS) && (32'(fx) < FB_WORDS_X);
  assign iss_fa  = FA_W'(32'(fy) * FB_WORDS_X + 32'(fx));
  assign rd_fa   = FA_W'(32'(in_fb_address));

  // funnel shift with spill from the previous word of the same row
  assign pc     = s1_first_r ? '0 : prev_col_r;
  assign pm     = s1_first_r ? '0 : prev_msk_r;
  assign sh_col = WORD_W'({pc, spr_rdata[31:16]} >> off_r);
  assign sh_msk = WORD_W'({pm, spr_rdata[15:0]} >> off_r);
  assign merged = (sh_col & sh_msk) | (fb_rdata & ~sh_msk);

  assign fb_we    = (state_r == ST_CLEAR) || (s1_vld_r && s1_wen_r);
  assign fb_waddr = (state_r == ST_CLEAR) ? clr_r : s1_fa_r;
  assign fb_wdata = (state_r == ST_CLEAR) ? {WORD_W{white_r}} : merged;
  assign fb_raddr = (state_r == ST_DRAW) ? iss_fa : rd_fa;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    col0_nxt      = col0_r;
    off_nxt       = off_r;
    py_nxt        = py_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    white_nxt     = white_r;
    clr_nxt       = clr_r;
    rd_ok_nxt     = rd_ok_r;
    s1_vld_nxt    = 1'b0;
    s1_wen_nxt    = iss_wen;
    s1_first_nxt  = (col_r == '0);
    s1_fa_nxt     = iss_fa;
    prev_col_nxt  = prev_col_r;
    prev_msk_nxt  = prev_msk_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_vld_r) begin
      prev_col_nxt = spr_rdata[31:16];
      prev_msk_nxt = spr_rdata[15:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_CLEAR: begin
              white_nxt = in_background_white;
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_DRAW: begin
              slot_nxt = in_sprite_index;
              col0_nxt = in_pos_x[8:4];
              off_nxt  = in_pos_x[3:0];
              py_nxt   = in_pos_y;
              row_nxt  = '0;
              col_nxt  = '0;
              if (slot_ok) begin
                state_nxt = ST_DRAW;
              end
            end
            CMD_READ: begin
              rd_ok_nxt = 32'(in_fb_address) < FB_DEPTH;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == FA_W'(FB_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW: begin
        s1_vld_nxt = 1'b1;
        if (col_r == C_W'(SPRITE_WORDS_X - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
          if (row_r == R_W'(SPRITE_ROWS - 1)) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_ok_r ? fb_rdata : '0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    col0_r     <= col0_nxt;
    off_r      <= off_nxt;
    py_r       <= py_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    white_r    <= white_nxt;
    clr_r      <= clr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    s1_wen_r   <= s1_wen_nxt;
    s1_first_r <= s1_first_nxt;
    s1_fa_r    <= s1_fa_nxt;
    prev_col_r <= prev_col_nxt;
    prev_msk_r <= prev_msk_nxt;
    out_data_r <= out_data_nxt;
  end

  msbl_ram #(.WIDTH(32), .DEPTH(SPR_DEPTH)) u_spr_ram (
    .clk   (clk),
    .we    (spr_we),
    .waddr (spr_waddr),
    .wdata ({in_color_word, in_alpha_word}),
    .raddr (spr_raddr),
    .rdata (spr_rdata)
  );

  msbl_ram #(.WIDTH(WORD_W), .DEPTH(FB_DEPTH)) u_fb_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

`default_nettype wire

// ----- src/msbl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the frame store and the sprite store.
`default_nettype none

module msbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/msbl_chk.sv -----
// Port-level checker for the sprite blitter, bound to the top level.
// Depends on msbl_pkg for command codes.
`default_nettype none

module msbl_chk import msbl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_read_data
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == CMD_READ) |-> ##2 out_valid)
    else $error("read transfer gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd != CMD_READ) && !out_valid |-> ##1 !out_valid ##1 !out_valid)
    else $error("result without read transfer");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result pending");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind masked_sprite_blitter_1bpp msbl_chk u_msbl_chk (.*);

`default_nettype wire
